// ----- rtl/drc_pkg.sv -----
package drc_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int SLOT_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int EDGE_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // result actions
  localparam logic [2:0] ACT_CLEARED  = 3'd0;
  localparam logic [2:0] ACT_EMPTY    = 3'd1;
  localparam logic [2:0] ACT_MERGED   = 3'd2;
  localparam logic [2:0] ACT_APPENDED = 3'd3;
  localparam logic [2:0] ACT_FULL     = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd2;

  localparam logic [15:0] SCALE_ONE = 16'd4096;

  typedef struct packed {
    logic               cmd;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [22:0]        extent_w;
    logic [22:0]        extent_h;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [13:0] edge_left;
    logic [13:0] edge_top;
    logic [13:0] edge_right;
    logic [13:0] edge_bottom;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [EDGE_W-1:0] l;
    logic [EDGE_W-1:0] t;
    logic [EDGE_W-1:0] r;
    logic [EDGE_W-1:0] b;
  } rect_t;

  typedef struct packed {
    logic [EDGE_W-1:0] frame_width;
    logic [EDGE_W-1:0] frame_height;
    logic [15:0]       scale;
  } cfg_t;

  // pixel rectangle leaving the front end
  typedef struct packed {
    logic  valid;
    logic  cmd;
    rect_t rect;
  } launch_t;

  // search token walking the cell row
  typedef struct packed {
    logic              valid;
    rect_t             rect;
    logic              found;
    logic [SLOT_W-1:0] slot;
    rect_t             hit_rect;
  } token_t;

endpackage

// ----- rtl/damage_rect_coalescer_core.sv -----
// Damage rectangle coalescer. Each add item carries a logical rectangle in
// signed q19.4; it is scaled by the q4.12 scale register (zero means 1.0),
// floored on left/top, ceiled on right/bottom and clamped to the frame size
// registers (zero means 1). Empty results are dropped, otherwise the pixel
// rectangle is unioned into the first held entry that it overlaps or touches,
// or appended; a full table drops it. A clear item empties the list. Every
// item gives exactly one result. Items are handled one at a time: a clear or
// an empty rectangle gets its result as it leaves the front end registers, an
// add once the search token that walks the row of entry cells one cell per
// clock has passed the last cell. The input stalls from transfer until the
// result has moved from the pending slot into the output register; a result
// held in the output register does not hold the next item back.
// Configuration writes are always ready and belong in idle periods.
module damage_rect_coalescer_core (
  input  logic                              clk,
  input  logic                              rst,
  // item input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  drc_pkg::in_item_t                 in_item,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output drc_pkg::out_item_t                out_item,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NCELL = drc_pkg::MAX_REGIONS;

  drc_pkg::cfg_t    cfg;
  drc_pkg::launch_t launch;
  drc_pkg::token_t  tok [NCELL+1];

  logic                        busy;
  logic                        in_take;
  logic [drc_pkg::CNT_W-1:0]   count, count_next;
  logic                        empty;
  logic                        append;
  logic [NCELL-1:0]            active, wr_sel;

  // result waiting for the output register
  logic                        pend_valid;
  drc_pkg::out_item_t          pend;
  logic                        res_valid;
  drc_pkg::out_item_t          res;
  logic                        pend_move;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign in_take = in_valid && !in_stall;
  assign pend_move = pend_valid && (!out_valid || !out_stall);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= 14'd1;
      cfg.frame_height <= 14'd1;
      cfg.scale <= drc_pkg::SCALE_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        drc_pkg::REG_FRAME_WIDTH:  cfg.frame_width <= cfg_data[13:0];
        drc_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[13:0];
        drc_pkg::REG_SCALE:        cfg.scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // scale, round and clamp
  drc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (in_take),
    .item   (in_item),
    .cfg    (cfg),
    .launch (launch)
  );

  // after clamping, right at or below left means empty as well
  assign empty = (launch.rect.r <= launch.rect.l) || (launch.rect.b <= launch.rect.t);

  // only non-empty adds enter the cell row
  always_comb begin
    tok[0].valid = launch.valid && launch.cmd && !empty;
    tok[0].rect = launch.rect;
    tok[0].found = 1'b0;
    tok[0].slot = '0;
    tok[0].hit_rect = launch.rect;
  end

  // one cell per table entry; the token moves one cell each clock
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    assign active[g] = drc_pkg::CNT_W'(g) < count;
    assign wr_sel[g] = append && (count == drc_pkg::CNT_W'(g));

    drc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (drc_pkg::SLOT_W'(g)),
      .active  (active[g]),
      .wr_en   (wr_sel[g]),
      .wr_rect (tok[NCELL].rect),
      .tin     (tok[g]),
      .tout    (tok[g+1])
    );
  end

  // result forming at the front end or at the end of the row
  always_comb begin
    res = '0;
    res_valid = 1'b0;
    append = 1'b0;
    count_next = count;
    priority if (launch.valid && !launch.cmd) begin
      res_valid = 1'b1;
      res.action = drc_pkg::ACT_CLEARED;
      count_next = '0;
    end else if (launch.valid && empty) begin
      res_valid = 1'b1;
      res.action = drc_pkg::ACT_EMPTY;
    end else if (tok[NCELL].valid) begin
      res_valid = 1'b1;
      priority if (tok[NCELL].found) begin
        res.action = drc_pkg::ACT_MERGED;
        res.slot = 4'(tok[NCELL].slot);
        res.edge_left = tok[NCELL].hit_rect.l;
        res.edge_top = tok[NCELL].hit_rect.t;
        res.edge_right = tok[NCELL].hit_rect.r;
        res.edge_bottom = tok[NCELL].hit_rect.b;
      end else if (count >= drc_pkg::CNT_W'(NCELL)) begin
        res.action = drc_pkg::ACT_FULL;
      end else begin
        // append at the first free entry
        append = 1'b1;
        count_next = count + drc_pkg::CNT_W'(1);
        res.action = drc_pkg::ACT_APPENDED;
        res.slot = 4'(count);
        res.edge_left = tok[NCELL].rect.l;
        res.edge_top = tok[NCELL].rect.t;
        res.edge_right = tok[NCELL].rect.r;
        res.edge_bottom = tok[NCELL].rect.b;
      end
    end else begin
      res_valid = 1'b0;
    end
    res.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;

      // busy from input transfer until the result leaves the pending slot
      if (in_take) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end

      if (res_valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end

      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (res_valid) begin
      pend <= res;
    end
    if (pend_move) begin
      out_item <= pend;
    end
  end

endmodule

// ----- rtl/drc_front.sv -----
module drc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  drc_pkg::in_item_t item,
  input  drc_pkg::cfg_t    cfg,
  output drc_pkg::launch_t launch
);

  // stage 1: logical edges, q21.4 in 26 bits
  logic               s1_valid;
  logic               s1_cmd;
  logic signed [25:0] s1_x0, s1_y0, s1_x1, s1_y1;

  // stage 2: scaled edges, 2^16 below a pixel
  logic               s2_valid;
  logic               s2_cmd;
  logic signed [43:0] s2_pl, s2_pt, s2_pr, s2_pb;

  logic [15:0]        scale_eff;
  logic signed [17:0] scale_mul;
  logic [13:0]        fw_eff, fh_eff;
  logic signed [43:0] ceil_r, ceil_b;

  function automatic logic [13:0] clamp_edge(input logic signed [27:0] q,
                                             input logic [13:0] hi);
    if (q < 0) begin
      return 14'd0;
    end else if (q > $signed({14'd0, hi})) begin
      return hi;
    end else begin
      return q[13:0];
    end
  endfunction

  assign scale_eff = (cfg.scale == 16'd0) ? drc_pkg::SCALE_ONE : cfg.scale;
  assign scale_mul = $signed({2'b00, scale_eff});
  assign fw_eff = (cfg.frame_width == 14'd0) ? 14'd1 : cfg.frame_width;
  assign fh_eff = (cfg.frame_height == 14'd0) ? 14'd1 : cfg.frame_height;

  // ceiling by biasing before the arithmetic shift
  assign ceil_r = s2_pr + 44'sd65535;
  assign ceil_b = s2_pb + 44'sd65535;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      launch.valid <= 1'b0;
    end else begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      launch.valid <= s2_valid;
    end

    s1_cmd <= item.cmd;
    s1_x0 <= {{2{item.origin_x[23]}}, item.origin_x};
    s1_y0 <= {{2{item.origin_y[23]}}, item.origin_y};
    s1_x1 <= {{2{item.origin_x[23]}}, item.origin_x} + $signed({3'b000, item.extent_w});
    s1_y1 <= {{2{item.origin_y[23]}}, item.origin_y} + $signed({3'b000, item.extent_h});

    s2_cmd <= s1_cmd;
    s2_pl <= s1_x0 * scale_mul;
    s2_pt <= s1_y0 * scale_mul;
    s2_pr <= s1_x1 * scale_mul;
    s2_pb <= s1_y1 * scale_mul;

    launch.cmd <= s2_cmd;
    launch.rect.l <= clamp_edge(s2_pl[43:16], fw_eff);
    launch.rect.t <= clamp_edge(s2_pt[43:16], fh_eff);
    launch.rect.r <= clamp_edge(ceil_r[43:16], fw_eff);
    launch.rect.b <= clamp_edge(ceil_b[43:16], fh_eff);
  end

endmodule

// ----- rtl/drc_cell.sv -----
module drc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [drc_pkg::SLOT_W-1:0]  idx,
  input  logic                        active,
  input  logic                        wr_en,
  input  drc_pkg::rect_t              wr_rect,
  input  drc_pkg::token_t             tin,
  output drc_pkg::token_t             tout
);

  drc_pkg::rect_t entry;
  drc_pkg::rect_t merged;
  logic           hit;

  // overlap or shared edge
  assign hit = tin.valid && !tin.found && active &&
               (entry.l <= tin.rect.r) && (entry.r >= tin.rect.l) &&
               (entry.t <= tin.rect.b) && (entry.b >= tin.rect.t);

  always_comb begin
    merged.l = (tin.rect.l < entry.l) ? tin.rect.l : entry.l;
    merged.t = (tin.rect.t < entry.t) ? tin.rect.t : entry.t;
    merged.r = (tin.rect.r > entry.r) ? tin.rect.r : entry.r;
    merged.b = (tin.rect.b > entry.b) ? tin.rect.b : entry.b;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_rect;
    end else if (hit) begin
      entry <= merged;
    end

    if (rst) begin
      tout <= '0;
    end else begin
      tout.valid <= tin.valid;
      tout.rect <= tin.rect;
      tout.found <= tin.found || hit;
      tout.slot <= hit ? idx : tin.slot;
      tout.hit_rect <= hit ? merged : tin.hit_rect;
    end
  end

endmodule
